FILE: sv/mdss_pkg.sv
package mdss_pkg;

  localparam int unsigned NumModes = 64;
  localparam int unsigned IdxW     = $clog2(NumModes);
  localparam int unsigned CntW     = $clog2(NumModes + 1);

  typedef enum logic [1:0] {
    ModeLoad    = 2'd0,
    ModeTick    = 2'd1,
    ModeRestart = 2'd2,
    ModeUnused  = 2'd3
  } mode_e;

  localparam logic [1:0] CfgGain     = 2'd0;
  localparam logic [1:0] CfgDuration = 2'd1;
  localparam logic [1:0] CfgCutoff   = 2'd2;
  localparam logic [1:0] CfgModes    = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         mode_index;
    logic signed [31:0] rotation_cosine;
    logic signed [31:0] rotation_sine;
    logic [31:0]        decay_factor;
    logic signed [31:0] mode_amplitude;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               finished;
    logic               clipped;
  } out_t;

  typedef struct packed {
    logic            load;
    logic            restart;
    logic            start;
    logic            rd;
    logic            mul1;
    logic            mul2;
    logic            mul3;
    logic            acc;
    logic            emit;
    logic            fin;
    logic [IdxW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic            expired;
    logic            live;
    logic [CntW-1:0] count;
  } sts_t;

endpackage

FILE: sv/mdss_ctrl.sv
module mdss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_mode_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mdss_pkg::sts_t      sts_i,
  output mdss_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_RD, S_MUL1, S_MUL2, S_MUL3, S_ACC, S_EMIT
  } state_e;

  state_e                      state_q, state_d;
  logic [mdss_pkg::CntW-1:0]   idx_q, idx_d;
  logic                        fin_q, fin_d;
  logic                        out_valid_q, out_valid_d;
  logic                        accept;
  logic                        emit_ok;
  logic                        last;
  logic [mdss_pkg::CntW-1:0]   idx_nxt;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign emit_ok     = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign idx_nxt     = idx_q + mdss_pkg::CntW'(1);
  assign last        = (idx_nxt == sts_i.count);

  always_comb begin
    cmd_o         = '0;
    cmd_o.idx     = idx_q[mdss_pkg::IdxW-1:0];
    cmd_o.fin     = fin_q;
    cmd_o.load    = accept && (in_mode_i == mdss_pkg::ModeLoad);
    cmd_o.restart = accept && (in_mode_i == mdss_pkg::ModeRestart);
    cmd_o.start   = (state_q == S_START);
    cmd_o.rd      = (state_q == S_RD);
    cmd_o.mul1    = (state_q == S_MUL1);
    cmd_o.mul2    = (state_q == S_MUL2);
    cmd_o.mul3    = (state_q == S_MUL3);
    cmd_o.acc     = (state_q == S_ACC);
    cmd_o.emit    = emit_ok;
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_mode_i == mdss_pkg::ModeTick) begin
          state_d = S_START;
        end
      end
      S_START: begin
        idx_d = '0;
        fin_d = sts_i.expired;
        if (sts_i.expired || sts_i.count == '0) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_MUL1;
      S_MUL1: begin
        if (sts_i.live) begin
          state_d = S_MUL2;
        end else begin
          idx_d   = idx_nxt;
          state_d = last ? S_EMIT : S_RD;
        end
      end
      S_MUL2: state_d = S_MUL3;
      S_MUL3: state_d = S_ACC;
      S_ACC: begin
        idx_d   = idx_nxt;
        state_d = last ? S_EMIT : S_RD;
      end
      S_EMIT: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: sv/mdss_dp.sv
module mdss_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  mdss_pkg::in_t       in_data_i,
  input  mdss_pkg::cmd_t      cmd_i,
  output mdss_pkg::sts_t      sts_o,
  output mdss_pkg::out_t      out_data_o
);

  localparam int unsigned N = mdss_pkg::NumModes;

  function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    return t[63:30];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // configuration
  logic [31:0] gain_q, cutoff_q;
  logic [17:0] dur_q;
  logic [6:0]  modes_q;

  // tables and oscillator state
  logic signed [31:0] tab_cr  [N];
  logic signed [31:0] tab_sr  [N];
  logic [31:0]        tab_dec [N];
  logic signed [31:0] tab_amp [N];
  logic signed [31:0] osc_s   [N];
  logic signed [31:0] osc_c   [N];
  logic [31:0]        env_mem [N];

  logic [N-1:0] fresh_q, alive_q;
  logic [17:0]  cnt_q;

  logic signed [31:0] rd_cr_q, rd_sr_q, rd_amp_q, rd_s_q, rd_c_q;
  logic [31:0]        rd_dec_q, rd_env_q;

  logic signed [31:0] sel_s, sel_c;
  logic [31:0]        sel_env, s_mag, a_mag;
  logic               kill;

  logic [63:0]        p_m1_q, p_env_q;
  logic signed [63:0] p_sc_q, p_cs_q, p_cc_q, p_ss_q;
  logic               neg_q;
  logic [31:0]        amag_q;
  logic [33:0]        m2_q;
  logic [63:0]        m2_prod;
  logic [65:0]        m3_prod;
  logic [48:0]        m3;
  logic signed [49:0] contrib_q;
  logic signed [34:0] sum_s, sum_c;
  logic signed [51:0] total;
  logic signed [19:0] q_fl, q_rt;
  logic signed [15:0] acc_q;
  logic               clip_q;
  logic [mdss_pkg::IdxW-1:0] widx;
  logic               wvalid;
  mdss_pkg::out_t     out_q;

  assign widx   = mdss_pkg::IdxW'(in_data_i.mode_index);
  assign wvalid = {26'b0, in_data_i.mode_index} < 32'(N);

  assign sel_s   = fresh_q[cmd_i.idx] ? 32'sd0 : rd_s_q;
  assign sel_c   = fresh_q[cmd_i.idx] ? 32'sd1073741824 : rd_c_q;
  assign sel_env = fresh_q[cmd_i.idx] ? 32'hffffffff : rd_env_q;
  assign s_mag   = sel_s[31] ? 32'(-sel_s) : sel_s;
  assign a_mag   = rd_amp_q[31] ? 32'(-rd_amp_q) : rd_amp_q;
  assign kill    = alive_q[cmd_i.idx] && (sel_env < cutoff_q);

  assign sts_o.live    = alive_q[cmd_i.idx] && (sel_env >= cutoff_q);
  assign sts_o.expired = (cnt_q >= dur_q);
  assign sts_o.count   = (modes_q > 7'(N)) ? mdss_pkg::CntW'(N)
                                           : mdss_pkg::CntW'(modes_q);

  assign m2_prod = {32'b0, p_m1_q[63:32]} * {32'b0, amag_q};
  assign m3_prod = {32'b0, m2_q} * {34'b0, gain_q};
  assign m3      = (m3_prod > 66'h1_0000_0000_0000) ? 49'h1_0000_0000_0000
                                                    : m3_prod[48:0];

  assign sum_s = 35'(rnd30(p_sc_q)) + 35'(rnd30(p_cs_q));
  assign sum_c = 35'(rnd30(p_cc_q)) - 35'(rnd30(p_ss_q));

  // sum truncated toward zero
  assign total = {{4{acc_q[15]}}, acc_q, 32'b0} + 52'(contrib_q);
  assign q_fl  = total[51:32];
  assign q_rt  = (total[51] && (total[31:0] != '0)) ? q_fl + 20'sd1 : q_fl;

  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= 32'd65536;
      dur_q    <= 18'd132300;
      cutoff_q <= 32'd4294967;
      modes_q  <= '0;
      fresh_q  <= '1;
      alive_q  <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mdss_pkg::CfgGain:     gain_q   <= cfg_data_i;
          mdss_pkg::CfgDuration: dur_q    <= cfg_data_i[17:0];
          mdss_pkg::CfgCutoff:   cutoff_q <= cfg_data_i;
          mdss_pkg::CfgModes:    modes_q  <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (cmd_i.restart) begin
        fresh_q <= '1;
        alive_q <= '1;
      end
      if (cmd_i.load && wvalid) begin
        fresh_q[widx] <= 1'b1;
        alive_q[widx] <= 1'b1;
      end
      if (cmd_i.mul1 && kill) begin
        alive_q[cmd_i.idx] <= 1'b0;
      end
      if (cmd_i.mul2) begin
        fresh_q[cmd_i.idx] <= 1'b0;
      end
      if (cmd_i.restart) begin
        cnt_q <= '0;
      end else if (cmd_i.emit && !cmd_i.fin) begin
        cnt_q <= cnt_q + 18'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wvalid) begin
      tab_cr[widx]  <= in_data_i.rotation_cosine;
      tab_sr[widx]  <= in_data_i.rotation_sine;
      tab_dec[widx] <= in_data_i.decay_factor;
      tab_amp[widx] <= in_data_i.mode_amplitude;
    end
    if (cmd_i.rd) begin
      rd_cr_q  <= tab_cr[cmd_i.idx];
      rd_sr_q  <= tab_sr[cmd_i.idx];
      rd_dec_q <= tab_dec[cmd_i.idx];
      rd_amp_q <= tab_amp[cmd_i.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2) begin
      osc_s[cmd_i.idx]   <= sat32(sum_s);
      osc_c[cmd_i.idx]   <= sat32(sum_c);
      env_mem[cmd_i.idx] <= p_env_q[63:32];
    end
    if (cmd_i.rd) begin
      rd_s_q   <= osc_s[cmd_i.idx];
      rd_c_q   <= osc_c[cmd_i.idx];
      rd_env_q <= env_mem[cmd_i.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      p_m1_q  <= {32'b0, s_mag} * {32'b0, sel_env};
      p_env_q <= {32'b0, sel_env} * {32'b0, rd_dec_q};
      p_sc_q  <= 64'(sel_s) * 64'(rd_cr_q);
      p_cs_q  <= 64'(sel_c) * 64'(rd_sr_q);
      p_cc_q  <= 64'(sel_c) * 64'(rd_cr_q);
      p_ss_q  <= 64'(sel_s) * 64'(rd_sr_q);
      neg_q   <= sel_s[31] ^ rd_amp_q[31];
      amag_q  <= a_mag;
    end
    if (cmd_i.mul2) begin
      m2_q <= m2_prod[63:30];
    end
    if (cmd_i.mul3) begin
      contrib_q <= neg_q ? -$signed({1'b0, m3}) : $signed({1'b0, m3});
    end
    if (cmd_i.start) begin
      acc_q  <= '0;
      clip_q <= 1'b0;
    end else if (cmd_i.acc) begin
      if (q_rt > 20'sd32767) begin
        acc_q  <= 16'sh7fff;
        clip_q <= 1'b1;
      end else if (q_rt < -20'sd32768) begin
        acc_q  <= 16'sh8000;
        clip_q <= 1'b1;
      end else begin
        acc_q <= q_rt[15:0];
      end
    end
    if (cmd_i.emit) begin
      out_q.sample   <= cmd_i.fin ? 16'sd0 : acc_q;
      out_q.finished <= cmd_i.fin;
      out_q.clipped  <= cmd_i.fin ? 1'b0 : clip_q;
    end
  end

endmodule

FILE: sv/modal_damped_sine_synth.sv
// load, restart and unused items give no result and leave the block idle
// tick: start, then per mode in use a table read and the product bank; a live mode
// goes on to the amplitude and gain multiplies and the add before the result is emitted;
// one item is in work at a time, the result register frees the input side
// reset: registers back to defaults, every mode marked not alive and its oscillator fresh
module modal_damped_sine_synth (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mdss_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mdss_pkg::out_t  out_data_o
);

  mdss_pkg::cmd_t cmd;
  mdss_pkg::sts_t sts;

  mdss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_data_i.mode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mdss_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

FILE: sv/mdss_checker.sv
module mdss_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            cfg_we_i,
  input logic [1:0]      cfg_idx_i,
  input logic [31:0]     cfg_data_i,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input mdss_pkg::in_t   in_data_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input mdss_pkg::out_t  out_data_o
);

  // a finished beat carries silence and no clip
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.finished |-> out_data_o.sample == 16'sd0 && !out_data_o.clipped)
    else $error("finished beat not silent");

  // a tick keeps the input side busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.mode == mdss_pkg::ModeTick |=> !in_ready_o)
    else $error("tick did not occupy the block");

  // a load finishes at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.mode == mdss_pkg::ModeLoad |=> in_ready_o)
    else $error("load held the input side");

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

endmodule

bind modal_damped_sine_synth mdss_checker u_mdss_checker (.*);

FILE: bench/tb_modal_damped_sine_synth.sv
module tb_modal_damped_sine_synth;

  class synth_scoreboard;
    logic signed [31:0] tab_cos [mdss_pkg::NumModes];
    logic signed [31:0] tab_sin [mdss_pkg::NumModes];
    logic [31:0]        tab_decay [mdss_pkg::NumModes];
    logic signed [31:0] tab_amp [mdss_pkg::NumModes];
    logic signed [31:0] osc_sin [mdss_pkg::NumModes];
    logic signed [31:0] osc_cos [mdss_pkg::NumModes];
    logic [31:0]        env [mdss_pkg::NumModes];
    bit                 alive [mdss_pkg::NumModes];
    logic [17:0]        sample_cnt;
    logic [31:0]        gain;
    logic [17:0]        duration;
    logic [31:0]        cutoff;
    logic [6:0]         modes_used;
    mdss_pkg::out_t     sample_q[$];
    int                 n_err;
    int                 n_ticks;
    int                 n_clipped;
    int                 n_finished;

    function new();
      for (int i = 0; i < mdss_pkg::NumModes; i++) begin
        osc_sin[i] = 32'sd0;
        osc_cos[i] = 32'sd1073741824;
        env[i] = '1;
        alive[i] = 1'b0;
      end
      sample_cnt = '0;
      gain = 32'd65536;
      duration = 18'd132300;
      cutoff = 32'd4294967;
      modes_used = '0;
      n_err = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        mdss_pkg::CfgGain:     gain = val;
        mdss_pkg::CfgDuration: duration = val[17:0];
        mdss_pkg::CfgCutoff:   cutoff = val;
        mdss_pkg::CfgModes:    modes_used = val[6:0];
        default: ;
      endcase
    endfunction

    function void fresh(int i);
      osc_sin[i] = 32'sd0;
      osc_cos[i] = 32'sd1073741824;
      env[i] = '1;
      alive[i] = 1'b1;
    endfunction

    function longint rnd30(longint p);
      return (p + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function mdss_pkg::out_t tick_sample();
      mdss_pkg::out_t r;
      int count;
      longint acc, total, q, contrib, s, c, a;
      bit [63:0] m1, m2, m3, e;
      bit clip;
      r = '0;
      if (sample_cnt >= duration) begin
        r.finished = 1'b1;
        return r;
      end
      count = (modes_used > mdss_pkg::NumModes) ? mdss_pkg::NumModes : int'(modes_used);
      acc = 0;
      clip = 1'b0;
      for (int i = 0; i < count; i++) begin
        if (!alive[i]) continue;
        if (env[i] < cutoff) begin
          alive[i] = 1'b0;
          continue;
        end
        s = osc_sin[i];
        c = osc_cos[i];
        a = tab_amp[i];
        m1 = ((s < 0 ? -s : s) * {32'd0, env[i]}) >> 32;
        m2 = (m1 * (a < 0 ? -a : a)) >> 30;
        m3 = m2 * {32'd0, gain};
        if (m3 > (64'd1 << 48)) m3 = 64'd1 << 48;
        contrib = ((s < 0) != (a < 0)) ? -longint'(m3) : longint'(m3);
        total = acc * 64'sd4294967296 + contrib;
        q = (total >= 0) ? (total >>> 32) : -((-total) >>> 32);
        if (q > 32767) begin
          q = 32767;
          clip = 1'b1;
        end
        if (q < -32768) begin
          q = -32768;
          clip = 1'b1;
        end
        acc = q;
        osc_sin[i] = sat32(rnd30(s * tab_cos[i]) + rnd30(c * tab_sin[i]));
        osc_cos[i] = sat32(rnd30(c * tab_cos[i]) - rnd30(s * tab_sin[i]));
        e = {32'd0, env[i]} * {32'd0, tab_decay[i]};
        env[i] = e[63:32];
      end
      sample_cnt = sample_cnt + 18'd1;
      r.sample = acc[15:0];
      r.clipped = clip;
      return r;
    endfunction

    function void note_item(mdss_pkg::in_t it);
      mdss_pkg::out_t r;
      case (mdss_pkg::mode_e'(it.mode))
        mdss_pkg::ModeLoad: begin
          tab_cos[it.mode_index] = it.rotation_cosine;
          tab_sin[it.mode_index] = it.rotation_sine;
          tab_decay[it.mode_index] = it.decay_factor;
          tab_amp[it.mode_index] = it.mode_amplitude;
          fresh(it.mode_index);
        end
        mdss_pkg::ModeRestart: begin
          sample_cnt = '0;
          for (int i = 0; i < mdss_pkg::NumModes; i++) fresh(i);
        end
        mdss_pkg::ModeTick: begin
          r = tick_sample();
          n_ticks++;
          if (r.clipped) n_clipped++;
          if (r.finished) n_finished++;
          sample_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_beat(mdss_pkg::out_t got);
      mdss_pkg::out_t want;
      if (sample_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected sample beat %p", got);
        return;
      end
      want = sample_q.pop_front();
      if (got.sample !== want.sample || got.finished !== want.finished ||
          got.clipped !== want.clipped) begin
        n_err++;
        if (n_err <= 10)
          $display("sample mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                   want.sample, want.finished, want.clipped,
                   got.sample, got.finished, got.clipped);
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [1:0]     cfg_idx_i;
  logic [31:0]    cfg_data_i;
  logic           in_valid_i;
  logic           in_ready_o;
  mdss_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_ready_i;
  mdss_pkg::out_t out_data_o;

  synth_scoreboard sb = new();
  bit calm;
  int n_items;

  modal_damped_sine_synth dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #60000000;
    $display("[modal_damped_sine_synth] ERROR");
    $finish;
  end

  initial out_ready_i = 0;
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_beat(out_data_o);
    out_ready_i <= calm || ($urandom_range(99) >= 27);
  end

  task automatic send_item(mdss_pkg::in_t it);
    if (!calm && $urandom_range(99) < 27) begin
      in_valid_i <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < 27);
    end
    in_valid_i <= 1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
    n_items++;
  endtask

  // registers change only once the block has drained
  task automatic write_regs(logic [31:0] g, logic [31:0] d, logic [31:0] c, logic [31:0] m);
    in_valid_i <= 0;
    while (sb.sample_q.size() != 0) @(posedge clk_i);
    repeat (340) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= mdss_pkg::CfgGain;     cfg_data_i <= g; @(posedge clk_i);
    sb.set_reg(mdss_pkg::CfgGain, g);
    cfg_idx_i <= mdss_pkg::CfgDuration; cfg_data_i <= d; @(posedge clk_i);
    sb.set_reg(mdss_pkg::CfgDuration, d);
    cfg_idx_i <= mdss_pkg::CfgCutoff;   cfg_data_i <= c; @(posedge clk_i);
    sb.set_reg(mdss_pkg::CfgCutoff, c);
    cfg_idx_i <= mdss_pkg::CfgModes;    cfg_data_i <= m; @(posedge clk_i);
    sb.set_reg(mdss_pkg::CfgModes, m);
    cfg_we_i <= 0;
  endtask

  function automatic mdss_pkg::in_t make_op(mdss_pkg::mode_e op);
    mdss_pkg::in_t it;
    it = '0;
    it.mode = op;
    it.mode_index = 6'($urandom_range(63));
    return it;
  endfunction

  // plausible mode: small rotation angle, slow decay, moderate amplitude; with noise, random values
  function automatic mdss_pkg::in_t make_load(int idx, bit noise);
    mdss_pkg::in_t it;
    longint s;
    it = make_op(mdss_pkg::ModeLoad);
    it.mode_index = 6'(idx);
    if (noise) begin
      it.rotation_cosine = $urandom_range(32'h80000000) - 32'h40000000;
      it.rotation_sine = $urandom_range(32'h80000000) - 32'h40000000;
      it.decay_factor = $urandom;
      it.mode_amplitude = $urandom;
    end else begin
      s = $urandom_range(1 << 27);
      it.rotation_sine = 32'($urandom_range(1) ? -s : s);
      it.rotation_cosine = 32'(64'sd1073741824 - ((s * s) >>> 31));
      it.decay_factor = 32'hfff00000 | ($urandom & 32'h000fffff);
      it.mode_amplitude = $urandom_range(3000 << 16);
      if ($urandom_range(1)) it.mode_amplitude = -it.mode_amplitude;
    end
    return it;
  endfunction

  initial begin
    mdss_pkg::in_t it;
    int r;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_idx_i = mdss_pkg::CfgGain;
    cfg_data_i = 0;
    in_valid_i = 0;
    in_data_i = '0;
    calm = 0;
    n_items = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // reset defaults, no modes in use, unused code
    send_item(make_op(mdss_pkg::ModeTick));
    send_item(make_op(mdss_pkg::ModeUnused));
    write_regs(32'd65536, 32'd262143, 32'd4294967, 32'd64);
    send_item(make_op(mdss_pkg::ModeTick));
    it = make_load(0, 0);
    it.rotation_cosine = -32'sd1073741824; it.rotation_sine = 32'sd1073741824;
    it.decay_factor = '1; it.mode_amplitude = 32'sh80000000;
    send_item(it);
    it = make_load(63, 0);
    it.rotation_cosine = 32'sd1073741824; it.rotation_sine = -32'sd1073741824;
    it.decay_factor = '0; it.mode_amplitude = 32'sh7fffffff;
    send_item(it);
    repeat (4) send_item(make_op(mdss_pkg::ModeTick));
    for (int i = 0; i < mdss_pkg::NumModes; i++) send_item(make_load(i, 0));
    send_item(make_op(mdss_pkg::ModeRestart));
    repeat (3) send_item(make_op(mdss_pkg::ModeTick));
    write_regs(32'd65536, 32'd5, 32'd0, 32'd2);
    repeat (7) send_item(make_op(mdss_pkg::ModeTick));
    send_item(make_op(mdss_pkg::ModeRestart));
    send_item(make_op(mdss_pkg::ModeTick));

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_regs(32'd65536, 32'd262143, 32'd4294967, 32'd64);
        1: write_regs(32'd0, 32'd262143, 32'd0, 32'd1);
        2: write_regs(32'hffffffff, 32'd262143, 32'hffffffff, 32'd64);
        3: write_regs(32'd1000 << 16, 32'd30, $urandom, 32'd8);
        4: write_regs(32'd0, 32'd0, 32'd0, 32'd3);
        default: write_regs($urandom, $urandom_range(262143), $urandom >> $urandom_range(31),
                            $urandom_range(64));
      endcase
      calm = (ph == 5);
      repeat (80) begin
        r = $urandom_range(99);
        if (r < 55) send_item(make_op(mdss_pkg::ModeTick));
        else if (r < 75) send_item(make_load($urandom_range(63), 0));
        else if (r < 88) send_item(make_load($urandom_range(63), 1));
        else if (r < 95) send_item(make_op(mdss_pkg::ModeRestart));
        else begin
          it = make_op(mdss_pkg::ModeUnused);
          it.rotation_cosine = $urandom; it.rotation_sine = $urandom;
          it.decay_factor = $urandom; it.mode_amplitude = $urandom;
          send_item(it);
        end
      end
      calm = 0;
    end

    in_valid_i <= 0;
    while (sb.sample_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("ran %0d items across nine register settings", n_items);
    $display("%0d samples, %0d clipped, %0d past end, %0d mismatches",
             sb.n_ticks, sb.n_clipped, sb.n_finished, sb.n_err);
    if (sb.n_err == 0) $display("[modal_damped_sine_synth] OK");
    else $display("[modal_damped_sine_synth] ERROR");
    $finish;
  end

endmodule
